@@ design/crc_checked_packet_deframer_assert.svh @@
// Concurrent check helpers used by the deframer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef CRC_CHECKED_PACKET_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define CCPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ccpd_pkg.sv @@
package ccpd_pkg;

    localparam int SLOT_W = 3;
    localparam int DESC_W = 64;

    localparam logic [7:0] SYNC_A    = 8'h61;
    localparam logic [7:0] SYNC_B    = 8'h2A;
    localparam logic [7:0] SYNC_C    = 8'h3E;
    localparam logic [15:0] CRC_INIT = 16'h00FF;

    localparam logic [1:0] REG_COUNT    = 2'd0;
    localparam logic [1:0] REG_DESC_LOW = 2'd1;
    localparam logic [1:0] REG_DESC_HI  = 2'd2;
    localparam logic [1:0] REG_ACK_MASK = 2'd3;

    typedef enum logic [3:0] {
        ST_HUNT     = 4'd0,
        ST_SYNC_B   = 4'd1,
        ST_SYNC_C   = 4'd2,
        ST_SIZE     = 4'd3,
        ST_TYPE     = 4'd4,
        ST_FLAG     = 4'd5,
        ST_PAYLOAD  = 4'd6,
        ST_CRC_LOW  = 4'd7,
        ST_CRC_HIGH = 4'd8
    } ccpd_state_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } ccpd_match_t;

    typedef struct packed {
        logic              payload_valid;
        logic [7:0]        payload_index;
        logic [7:0]        payload_byte;
        logic              frame_done;
        logic              crc_ok;
        logic [7:0]        packet_type;
        logic [7:0]        packet_flag;
        logic              type_matched;
        logic [SLOT_W-1:0] matched_slot;
        logic              ack_request;
    } ccpd_result_t;

    // Reflected CCITT step (poly 0x8408), one byte.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] d;
        d = data ^ crc[7:0];
        d = d ^ {d[3:0], 4'h0};
        return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
    endfunction

endpackage

@@ design/ccpd_slot_match.sv @@
module ccpd_slot_match #(
    parameter int MAX_SLOTS = 8
) (
    input  logic [ccpd_pkg::DESC_W-1:0] descriptors,
    input  logic [3:0]                  registered_count,
    input  logic [7:0]                  packet_type,
    output ccpd_pkg::ccpd_match_t       slot_hit
);
    import ccpd_pkg::*;

    logic [MAX_SLOTS-1:0] eq;

    // Slots at or above the count never hit; counts past MAX_SLOTS saturate naturally.
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            eq[i] = (descriptors[8*i +: 8] == packet_type) && (4'(i) < registered_count);
        end
    end

    // Lowest slot wins.
    always_comb
    begin
        slot_hit.hit  = |eq;
        slot_hit.slot = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (eq[i])
            begin
                slot_hit.slot = SLOT_W'(i);
            end
        end
    end

endmodule

@@ design/crc_checked_packet_deframer.sv @@
// A byte taken into the input hold register moves on to the result register, which drives res_valid.
// Throughput: one byte per cycle while res_ready is not stalling; the frame state, CRC step and
// slot compare all sit in the single stage between the input hold register and the result register.
// Back-pressure on res_ready stalls the input hold register, then rx_ready.
// Reset (rst_n low, asynchronous): both stages empty, hunting for sync, CRC at 0x00FF,
// registered_count and descriptors 0, ack_mask 1.
`include "crc_checked_packet_deframer_assert.svh"

module crc_checked_packet_deframer #(
    parameter int MAX_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,

    output logic        res_valid,
    input  logic        res_ready,
    output logic        payload_valid,
    output logic [7:0]  payload_index,
    output logic [7:0]  payload_byte,
    output logic        frame_done,
    output logic        crc_ok,
    output logic [7:0]  packet_type,
    output logic [7:0]  packet_flag,
    output logic        type_matched,
    output logic [2:0]  matched_slot,
    output logic        ack_request
);
    import ccpd_pkg::*;

    // Configuration registers
    logic [3:0]  count_reg;
    logic [31:0] desc_low_reg;
    logic [31:0] desc_high_reg;
    logic [7:0]  ack_mask_reg;
    logic        cfg_write;

    // Pipeline
    logic         rx_full_reg;
    logic [7:0]   rx_hold_reg;
    logic         res_valid_reg;
    ccpd_result_t res_reg;
    ccpd_result_t res_next;
    logic         advance;
    logic         rx_take;

    // Frame state
    ccpd_state_t  state_reg, state_next;
    logic [7:0]   length_reg, length_next;
    logic [7:0]   left_reg, left_next;
    logic [7:0]   type_reg, type_next;
    logic [7:0]   flag_reg, flag_next;
    logic [15:0]  crc_reg, crc_next;
    logic [7:0]   cksum_low_reg, cksum_low_next;

    ccpd_match_t  slot_hit;
    logic [15:0]  crc_stepped;
    logic         crc_equal;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 4'd0;
            desc_low_reg  <= 32'd0;
            desc_high_reg <= 32'd0;
            ack_mask_reg  <= 8'd1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_COUNT:    count_reg     <= pwdata[3:0];
                REG_DESC_LOW: desc_low_reg  <= pwdata;
                REG_DESC_HI:  desc_high_reg <= pwdata;
                REG_ACK_MASK: ack_mask_reg  <= pwdata[7:0];
                default:      count_reg     <= count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_COUNT:    prdata = {28'd0, count_reg};
            REG_DESC_LOW: prdata = desc_low_reg;
            REG_DESC_HI:  prdata = desc_high_reg;
            REG_ACK_MASK: prdata = {24'd0, ack_mask_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input hold stage, then result stage
    // ------------------------------------------------------------------
    assign advance  = rx_full_reg && (!res_valid_reg || res_ready);
    assign rx_ready = !rx_full_reg || advance;
    assign rx_take  = rx_valid && rx_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_full_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_take)
            begin
                rx_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                rx_full_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            rx_hold_reg <= rx_byte;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Frame state machine
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            length_reg    <= 8'd0;
            left_reg      <= 8'd0;
            type_reg      <= 8'd0;
            flag_reg      <= 8'd0;
            crc_reg       <= CRC_INIT;
            cksum_low_reg <= 8'd0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            left_reg      <= left_next;
            type_reg      <= type_next;
            flag_reg      <= flag_next;
            crc_reg       <= crc_next;
            cksum_low_reg <= cksum_low_next;
        end
    end

    ccpd_slot_match #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_slot_match (
        .descriptors      ({desc_high_reg, desc_low_reg}),
        .registered_count (count_reg),
        .packet_type      (type_reg),
        .slot_hit         (slot_hit)
    );

    // Type byte restarts the CRC from the init value.
    assign crc_stepped = crc_step((state_reg == ST_TYPE) ? CRC_INIT : crc_reg, rx_hold_reg);
    assign crc_equal   = ({rx_hold_reg, cksum_low_reg} == crc_reg);

    always_comb
    begin
        state_next     = ST_HUNT;
        length_next    = length_reg;
        left_next      = left_reg;
        type_next      = type_reg;
        flag_next      = flag_reg;
        crc_next       = crc_reg;
        cksum_low_next = cksum_low_reg;
        res_next       = '0;

        case (state_reg)
            ST_HUNT:
            begin
                state_next     = (rx_hold_reg == SYNC_A) ? ST_SYNC_B : ST_HUNT;
                left_next      = 8'd0;
                length_next    = 8'd0;
                flag_next      = 8'd0;
                cksum_low_next = 8'd0;
            end
            ST_SYNC_B:
            begin
                state_next = (rx_hold_reg == SYNC_B) ? ST_SYNC_C : ST_HUNT;
            end
            ST_SYNC_C:
            begin
                state_next = (rx_hold_reg == SYNC_C) ? ST_SIZE : ST_HUNT;
            end
            ST_SIZE:
            begin
                length_next = rx_hold_reg;
                state_next  = ST_TYPE;
            end
            ST_TYPE:
            begin
                type_next = rx_hold_reg;
                crc_next  = crc_stepped;
                // drop empty frames here
                if (length_reg == 8'd0)
                begin
                    state_next = ST_HUNT;
                end
                else
                begin
                    left_next  = length_reg;
                    state_next = ST_FLAG;
                end
            end
            ST_FLAG:
            begin
                flag_next  = rx_hold_reg;
                crc_next   = crc_stepped;
                state_next = ST_PAYLOAD;
            end
            ST_PAYLOAD:
            begin
                res_next.payload_valid = 1'b1;
                res_next.payload_index = length_reg - left_reg;
                res_next.payload_byte  = rx_hold_reg;
                crc_next               = crc_stepped;
                left_next              = left_reg - 8'd1;
                state_next             = (left_reg == 8'd1) ? ST_CRC_LOW : ST_PAYLOAD;
            end
            ST_CRC_LOW:
            begin
                cksum_low_next = rx_hold_reg;
                state_next     = ST_CRC_HIGH;
            end
            ST_CRC_HIGH:
            begin
                res_next.frame_done   = 1'b1;
                res_next.crc_ok       = crc_equal;
                res_next.packet_type  = type_reg;
                res_next.packet_flag  = flag_reg;
                res_next.type_matched = crc_equal && slot_hit.hit;
                res_next.matched_slot = (crc_equal && slot_hit.hit) ? slot_hit.slot : '0;
                res_next.ack_request  = crc_equal && slot_hit.hit && (|(flag_reg & ack_mask_reg));
                state_next            = ST_HUNT;
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign res_valid     = res_valid_reg;
    assign payload_valid = res_reg.payload_valid;
    assign payload_index = res_reg.payload_index;
    assign payload_byte  = res_reg.payload_byte;
    assign frame_done    = res_reg.frame_done;
    assign crc_ok        = res_reg.crc_ok;
    assign packet_type   = res_reg.packet_type;
    assign packet_flag   = res_reg.packet_flag;
    assign type_matched  = res_reg.type_matched;
    assign matched_slot  = res_reg.matched_slot;
    assign ack_request   = res_reg.ack_request;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `CCPD_ASSERT_NEXT(a_payload_emits, advance && (state_reg == ST_PAYLOAD),
        res_valid_reg && res_reg.payload_valid, "payload byte did not produce a payload transaction")
    `CCPD_ASSERT_NEXT(a_frame_end_hunts, advance && (state_reg == ST_CRC_HIGH),
        (state_reg == ST_HUNT) && res_reg.frame_done, "frame end did not report and return to hunt")
    `CCPD_ASSERT_SAME(a_done_excl_payload, res_valid_reg && res_reg.frame_done,
        !res_reg.payload_valid, "frame_done and payload_valid both set")
    `CCPD_ASSERT_SAME(a_match_needs_crc, res_valid_reg && res_reg.type_matched,
        res_reg.crc_ok && res_reg.frame_done, "type match reported without a good checksum")
    `CCPD_ASSERT_SAME(a_ack_needs_match, res_valid_reg && res_reg.ack_request,
        res_reg.type_matched, "ack requested without a type match")

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccpd_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int SLOT_CAP    = 8;
    localparam int IDLE_PCT    = 23;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CRC_LO,
        ROW_CRC_HI
    } row_kind_t;

    // For checksum rows, data is XORed into the checksum byte (zero keeps it correct)
    typedef struct packed {
        logic [7:0]   data;
        row_kind_t    kind;
        logic         typed;
        ccpd_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic        payload_valid;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic        crc_ok;
    logic [7:0]  packet_type;
    logic [7:0]  packet_flag;
    logic        type_matched;
    logic [2:0]  matched_slot;
    logic        ack_request;

    // Register copies
    logic [3:0]  cfg_slots = 4'd0;
    logic [31:0] cfg_desc_lo = 32'd0;
    logic [31:0] cfg_desc_hi = 32'd0;
    logic [7:0]  cfg_ack_mask = 8'd1;

    // Parser state copy
    ccpd_state_t parse_state = ST_HUNT;
    logic [7:0]  frame_len = 8'd0;
    logic [7:0]  left_count = 8'd0;
    logic [7:0]  held_type = 8'd0;
    logic [7:0]  held_flag = 8'd0;
    logic [7:0]  crc_low_rx = 8'd0;
    logic [15:0] crc_acc = CRC_INIT;

    ccpd_result_t deframer_outputs_due[$];
    ccpd_result_t seen_out;
    ccpd_result_t due_out;
    stim_row_t    directed_rows[$];

    int errors = 0;
    int cycle_count = 0;
    int frame_bytes = 0;
    bit steady = 1'b0;

    crc_checked_packet_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .payload_valid (payload_valid),
        .payload_index (payload_index),
        .payload_byte  (payload_byte),
        .frame_done    (frame_done),
        .crc_ok        (crc_ok),
        .packet_type   (packet_type),
        .packet_flag   (packet_flag),
        .type_matched  (type_matched),
        .matched_slot  (matched_slot),
        .ack_request   (ack_request)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bitwise reflected CCITT, polynomial 0x8408
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        x = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++)
            x = x[0] ? ((x >> 1) ^ 16'h8408) : (x >> 1);
        return x;
    endfunction

    function automatic ccpd_result_t deframe_byte(input logic [7:0] b);
        ccpd_result_t r;
        logic [63:0]  slot_bytes;
        logic [15:0]  rx_crc;
        int           n;
        r = '0;
        case (parse_state)
            ST_HUNT:
            begin
                parse_state = (b == SYNC_A) ? ST_SYNC_B : ST_HUNT;
                left_count = 8'd0;
                frame_len = 8'd0;
                held_flag = 8'd0;
                crc_low_rx = 8'd0;
            end
            ST_SYNC_B: parse_state = (b == SYNC_B) ? ST_SYNC_C : ST_HUNT;
            ST_SYNC_C: parse_state = (b == SYNC_C) ? ST_SIZE : ST_HUNT;
            ST_SIZE:
            begin
                frame_len = b;
                parse_state = ST_TYPE;
            end
            ST_TYPE:
            begin
                held_type = b;
                crc_acc = crc_byte(CRC_INIT, b);
                if (frame_len == 8'd0)
                    parse_state = ST_HUNT;
                else
                begin
                    left_count = frame_len;
                    parse_state = ST_FLAG;
                end
            end
            ST_FLAG:
            begin
                held_flag = b;
                crc_acc = crc_byte(crc_acc, b);
                parse_state = ST_PAYLOAD;
            end
            ST_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.payload_index = frame_len - left_count;
                r.payload_byte = b;
                crc_acc = crc_byte(crc_acc, b);
                left_count = left_count - 8'd1;
                if (left_count == 8'd0)
                    parse_state = ST_CRC_LOW;
            end
            ST_CRC_LOW:
            begin
                crc_low_rx = b;
                parse_state = ST_CRC_HIGH;
            end
            ST_CRC_HIGH:
            begin
                rx_crc = {b, crc_low_rx};
                slot_bytes = {cfg_desc_hi, cfg_desc_lo};
                n = (cfg_slots > SLOT_CAP) ? SLOT_CAP : int'(cfg_slots);
                r.frame_done = 1'b1;
                r.crc_ok = (rx_crc == crc_acc);
                r.packet_type = held_type;
                r.packet_flag = held_flag;
                if (r.crc_ok)
                begin
                    // lowest matching slot wins
                    for (int i = 0; i < n; i++)
                    begin
                        if (!r.type_matched && slot_bytes[8*i +: 8] == held_type)
                        begin
                            r.type_matched = 1'b1;
                            r.matched_slot = 3'(i);
                        end
                    end
                end
                r.ack_request = r.type_matched && ((held_flag & cfg_ack_mask) != 8'd0);
                parse_state = ST_HUNT;
            end
            default: parse_state = ST_HUNT;
        endcase
        return r;
    endfunction

    function automatic stim_row_t row(input logic [7:0] data, input row_kind_t kind,
                                      input logic typed, input ccpd_result_t want);
        stim_row_t s;
        s.data = data;
        s.kind = kind;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    function automatic ccpd_result_t payload_only(input logic [7:0] idx, input logic [7:0] b);
        ccpd_result_t r;
        r = '0;
        r.payload_valid = 1'b1;
        r.payload_index = idx;
        r.payload_byte = b;
        return r;
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COUNT:    cfg_slots = value[3:0];
            REG_DESC_LOW: cfg_desc_lo = value;
            REG_DESC_HI:  cfg_desc_hi = value;
            REG_ACK_MASK: cfg_ack_mask = value[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed, input ccpd_result_t want);
        ccpd_result_t predicted;
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!rx_ready);
        predicted = deframe_byte(b);
        deframer_outputs_due.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        rx_valid <= 1'b0;
        do @(posedge clk); while (deframer_outputs_due.size() != 0);
    endtask

    task automatic send_frame(input bit max_len);
        logic [7:0]  frame_q[$];
        logic [7:0]  len;
        logic [7:0]  ptype;
        logic [7:0]  pb;
        logic [15:0] crc;
        logic [63:0] slot_bytes;
        int          pick;
        slot_bytes = {cfg_desc_hi, cfg_desc_lo};
        pick = $urandom_range(99);
        if (max_len)
            len = 8'hFF;
        else if (pick < 4)
            len = 8'h00;
        else if (pick < 7)
            len = 8'($urandom_range(9, 255));
        else
            len = 8'($urandom_range(1, 8));
        // steer most types onto a descriptor so matches are common
        if ($urandom_range(3) != 0)
            ptype = slot_bytes[8*$urandom_range(7) +: 8];
        else
            ptype = 8'($urandom);
        frame_q = '{SYNC_A, SYNC_B, SYNC_C, len, ptype};
        crc = crc_byte(CRC_INIT, ptype);
        if (len != 8'd0)
        begin
            pb = 8'($urandom);
            frame_q.push_back(pb);
            crc = crc_byte(crc, pb);
            repeat (len)
            begin
                pb = 8'($urandom);
                frame_q.push_back(pb);
                crc = crc_byte(crc, pb);
            end
            if ($urandom_range(9) == 0)
                crc = crc ^ (16'd1 << $urandom_range(15));
            frame_q.push_back(crc[7:0]);
            frame_q.push_back(crc[15:8]);
        end
        // break some frames: corrupt a sync byte or truncate
        if ($urandom_range(15) == 0)
            frame_q[$urandom_range(2)] = 8'($urandom);
        if (!max_len && $urandom_range(11) == 0)
            while (frame_q.size() > $urandom_range(1, frame_q.size() - 1))
                void'(frame_q.pop_back());
        foreach (frame_q[k])
            send_byte(frame_q[k], 1'b0, '0);
        frame_bytes += frame_q.size();
    endtask

    task automatic run_phase(input logic [3:0] slots, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [7:0] mask,
                             input bit calm, input bit big_first, input int budget);
        int stop_at;
        int burst;
        int pick;
        cfg_write(REG_COUNT, {28'd0, slots});
        cfg_write(REG_DESC_LOW, lo);
        cfg_write(REG_DESC_HI, hi);
        cfg_write(REG_ACK_MASK, {24'd0, mask});
        steady = calm;
        stop_at = frame_bytes + budget;
        if (big_first)
            send_frame(1'b1);
        while (frame_bytes < stop_at)
        begin
            if ($urandom_range(99) < 85)
                send_frame(1'b0);
            else
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                begin
                    pick = $urandom_range(5);
                    case (pick)
                        0: send_byte(SYNC_A, 1'b0, '0);
                        1: send_byte(SYNC_B, 1'b0, '0);
                        2: send_byte(SYNC_C, 1'b0, '0);
                        default: send_byte(8'($urandom), 1'b0, '0);
                    endcase
                end
            end
        end
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        res_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && res_valid && res_ready)
        begin
            seen_out = {payload_valid, payload_index, payload_byte, frame_done, crc_ok,
                        packet_type, packet_flag, type_matched, matched_slot, ack_request};
            if (deframer_outputs_due.size() == 0)
            begin
                errors++;
                $display("%0t: transaction with nothing pending: expected none, actual %h",
                         $time, seen_out);
            end
            else
            begin
                due_out = deframer_outputs_due.pop_front();
                check_field("payload_valid", 8'(due_out.payload_valid),
                            8'(seen_out.payload_valid));
                check_field("payload_index", due_out.payload_index, seen_out.payload_index);
                check_field("payload_byte", due_out.payload_byte, seen_out.payload_byte);
                check_field("frame_done", 8'(due_out.frame_done), 8'(seen_out.frame_done));
                check_field("crc_ok", 8'(due_out.crc_ok), 8'(seen_out.crc_ok));
                check_field("packet_type", due_out.packet_type, seen_out.packet_type);
                check_field("packet_flag", due_out.packet_flag, seen_out.packet_flag);
                check_field("type_matched", 8'(due_out.type_matched),
                            8'(seen_out.type_matched));
                check_field("matched_slot", 8'(due_out.matched_slot),
                            8'(seen_out.matched_slot));
                check_field("ack_request", 8'(due_out.ack_request),
                            8'(seen_out.ack_request));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   cur;
        logic [7:0]  b;
        logic [31:0] lo;

        // idle bytes, an 'a' that is not rechecked after a failed sync, zero size,
        // a good one-byte frame, then a frame with a bad checksum high byte
        directed_rows.push_back(row(8'h00, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_A, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_A, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_B, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_A, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_B, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_C, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'h00, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'hFF, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_A, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_B, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_C, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'h01, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'hFF, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'hFF, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'h00, ROW_BYTE, 1'b1, payload_only(8'd0, 8'h00)));
        directed_rows.push_back(row(8'h00, ROW_CRC_LO, 1'b1, '0));
        directed_rows.push_back(row(8'h00, ROW_CRC_HI, 1'b0, '0));
        directed_rows.push_back(row(SYNC_A, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_B, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(SYNC_C, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'h01, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'h00, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'h00, ROW_BYTE, 1'b1, '0));
        directed_rows.push_back(row(8'hFF, ROW_BYTE, 1'b1, payload_only(8'd0, 8'hFF)));
        directed_rows.push_back(row(8'h00, ROW_CRC_LO, 1'b1, '0));
        directed_rows.push_back(row(8'h80, ROW_CRC_HI, 1'b0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            cur = directed_rows[k];
            case (cur.kind)
                ROW_CRC_LO: b = cur.data ^ crc_acc[7:0];
                ROW_CRC_HI: b = cur.data ^ crc_acc[15:8];
                default:    b = cur.data;
            endcase
            send_byte(b, cur.typed, cur.want);
        end
        wait_drained();

        // slot 4 repeats slot 2 so the lowest match must be reported
        lo = $urandom;
        run_phase(4'd8, lo, {24'($urandom), lo[23:16]}, 8'hFF, 1'b0, 1'b1, 330);
        run_phase(4'd15, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 100);
        run_phase(4'd1, $urandom, $urandom, 8'h80, 1'b1, 1'b0, 100);
        run_phase(4'd0, $urandom, $urandom, 8'hFF, 1'b0, 1'b0, 100);
        run_phase(4'($urandom_range(15)), $urandom, $urandom, 8'($urandom), 1'b0, 1'b0, 100);

        repeat (8) @(posedge clk);
        if (errors == 0 && deframer_outputs_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ crc_checked_packet_deframer.f @@
+incdir+design
design/ccpd_pkg.sv
design/ccpd_slot_match.sv
design/crc_checked_packet_deframer.sv
test/tb.sv
